### design/dmwbc_pkg.sv
// dmwbc_pkg: shared constants for the direct-mapped write-back cache
// field widths and default geometry; no dependencies
`default_nettype none

package dmwbc_pkg;

  localparam int ADDR_W = 16;  // byte address width
  localparam int DATA_W = 8;   // byte width

  localparam int NUM_LINES_DEF  = 32;
  localparam int LINE_BYTES_DEF = 8;
  localparam int MEM_BYTES_DEF  = 65536;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

endpackage

`default_nettype wire

### design/dmwbc_if.sv
// dmwbc_in_if / dmwbc_out_if: valid/ready channels of the cache
// depends on dmwbc_pkg for field widths
`default_nettype none

interface dmwbc_in_if import dmwbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              action;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output address, output action, output write_data,
                  input ready);
  modport sink   (input valid, input address, input action, input write_data,
                  output ready);
endinterface

interface dmwbc_out_if import dmwbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              hit;
  logic              was_dirty;

  modport source (output valid, output read_data, output hit, output was_dirty,
                  input ready);
  modport sink   (input valid, input read_data, input hit, input was_dirty,
                  output ready);
endinterface

`default_nettype wire

### design/dmwbc_ram.sv
// dmwbc_ram: generic simple dual-port ram, one write and one registered read
// depends on dmwbc_pkg for default width
`default_nettype none

module dmwbc_ram import dmwbc_pkg::*; #(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = NUM_LINES_DEF * LINE_BYTES_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### design/direct_mapped_writeback_cache.sv
// direct_mapped_writeback_cache: direct-mapped write-back write-allocate byte cache
// with its backing memory inside; depends on dmwbc_pkg, dmwbc_if, dmwbc_ram
//
//   channel   dir  signals                              word
//   in_chan   in   valid ready address action write_data one access (read or write)
//   out_chan  out  valid ready read_data hit was_dirty  one read result
//
// read hit: ST_LOOKUP, ST_ACCESS, then ST_RESP loads the output register; write hit:
// ST_LOOKUP and ST_ACCESS; a miss adds the ST_FILL line fetch, a dirty miss first the
// ST_WB write-back; one byte moves per cycle through the backing-memory write port
// (write-back) or read port (fill), driven by the shared transfer counter
// after reset every backing-memory byte is cleared to zero before in_chan.ready
// a result waits in the output register; the next access is taken meanwhile, and a
// read only stalls in ST_RESP if the previous result has not been taken
// NUM_LINES, LINE_BYTES and MEM_BYTES are powers of two
`default_nettype none

module direct_mapped_writeback_cache import dmwbc_pkg::*; #(
  parameter int NUM_LINES  = NUM_LINES_DEF,
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  parameter int MEM_BYTES  = MEM_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  dmwbc_in_if.sink   in_chan,
  dmwbc_out_if.source out_chan
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(NUM_LINES);
  localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
  localparam int LRAM_W = OFF_W + IDX_W;          // line byte store address
  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int CNT_W  = OFF_W + 1;              // holds 0..LINE_BYTES

  // sequencer states
  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,  // zero the backing memory after reset
    ST_IDLE   = 7'b0000010,  // take a word
    ST_LOOKUP = 7'b0000100,  // tag compare
    ST_WB     = 7'b0001000,  // write dirty line back, one byte a cycle
    ST_FILL   = 7'b0010000,  // fetch new line, one byte a cycle
    ST_ACCESS = 7'b0100000,  // byte write or byte read issue
    ST_RESP   = 7'b1000000   // load output register
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [MEM_AW-1:0]   clr_cnt_r;

  // request holding registers
  logic [ADDR_W-1:0]   addr_r;
  logic                act_r;
  logic [DATA_W-1:0]   wdata_r;
  logic                hit_r;
  logic                old_dirty_r;

  // line state kept in flops
  logic [NUM_LINES-1:0] line_valid_r;
  logic [NUM_LINES-1:0] line_dirty_r;
  logic [TAG_W-1:0]     line_tag_r [NUM_LINES];

  // output register
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic                out_hit_r;
  logic                out_dirty_r;

  // address split
  logic [OFF_W-1:0] off_r;
  logic [IDX_W-1:0] idx_r;
  logic [TAG_W-1:0] tag_r;
  assign off_r = addr_r[OFF_W-1:0];
  assign idx_r = addr_r[OFF_W +: IDX_W];
  assign tag_r = addr_r[ADDR_W-1 -: TAG_W];

  // transfer counter: issue byte cnt, complete byte cnt-1
  logic [CNT_W-1:0] cnt_prev;
  logic             cnt_done;
  logic             cnt_busy;
  assign cnt_prev = cnt_r - CNT_W'(1);
  assign cnt_done = (cnt_r == CNT_W'(LINE_BYTES));
  assign cnt_busy = (cnt_r != '0);

  logic lookup_hit;
  assign lookup_hit = line_valid_r[idx_r] && (line_tag_r[idx_r] == tag_r);

  logic out_free;
  assign out_free = !out_valid_r || out_chan.ready;

  logic in_acc;
  assign in_acc = in_chan.valid && in_chan.ready;

  // line byte store ports
  logic              lram_we;
  logic [LRAM_W-1:0] lram_waddr, lram_raddr;
  logic [DATA_W-1:0] lram_wdata, lram_rdata;

  // backing memory ports
  logic              bmem_we;
  logic [MEM_AW-1:0] bmem_waddr, bmem_raddr;
  logic [DATA_W-1:0] bmem_wdata, bmem_rdata;

  logic [ADDR_W-1:0] wb_full_addr, fill_full_addr;
  assign wb_full_addr   = {line_tag_r[idx_r], idx_r, cnt_prev[OFF_W-1:0]};
  assign fill_full_addr = {tag_r, idx_r, cnt_r[OFF_W-1:0]};

  always_comb begin
    // line store read: stream during write-back, else the addressed byte
    lram_raddr = (state_r == ST_WB) ? {idx_r, cnt_r[OFF_W-1:0]} : {idx_r, off_r};

    lram_we    = 1'b0;
    lram_waddr = {idx_r, cnt_prev[OFF_W-1:0]};
    lram_wdata = bmem_rdata;
    if (state_r == ST_FILL && cnt_busy) begin
      lram_we = 1'b1;
    end else if (state_r == ST_ACCESS && act_r == ACT_WRITE) begin
      lram_we    = 1'b1;
      lram_waddr = {idx_r, off_r};
      lram_wdata = wdata_r;
    end

    bmem_raddr = fill_full_addr[MEM_AW-1:0];
    bmem_we    = 1'b0;
    bmem_waddr = wb_full_addr[MEM_AW-1:0];
    bmem_wdata = lram_rdata;
    if (state_r == ST_CLEAR) begin
      bmem_we    = 1'b1;
      bmem_waddr = clr_cnt_r;
      bmem_wdata = '0;
    end else if (state_r == ST_WB && cnt_busy) begin
      bmem_we = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == MEM_AW'(MEM_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cnt_nxt = '0;
        if (lookup_hit) begin
          state_nxt = ST_ACCESS;
        end else if (line_valid_r[idx_r] && line_dirty_r[idx_r]) begin
          state_nxt = ST_WB;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_WB: begin
        if (cnt_done) begin
          cnt_nxt   = '0;
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_FILL: begin
        if (cnt_done) begin
          cnt_nxt   = '0;
          state_nxt = ST_ACCESS;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_ACCESS: begin
        state_nxt = (act_r == ACT_WRITE) ? ST_IDLE : ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      clr_cnt_r    <= '0;
      line_valid_r <= '0;
      line_dirty_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
      end
      // new line installed once the fill has landed
      if (state_r == ST_FILL && cnt_done) begin
        line_valid_r[idx_r] <= 1'b1;
      end
      if (state_r == ST_ACCESS) begin
        if (act_r == ACT_WRITE) begin
          line_dirty_r[idx_r] <= 1'b1;
        end else if (!hit_r) begin
          line_dirty_r[idx_r] <= 1'b0;
        end
      end
      if (state_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r  <= in_chan.address;
      act_r   <= in_chan.action;
      wdata_r <= in_chan.write_data;
    end
    if (state_r == ST_LOOKUP) begin
      hit_r       <= lookup_hit;
      old_dirty_r <= line_dirty_r[idx_r];
    end
    if (state_r == ST_FILL && cnt_done) begin
      line_tag_r[idx_r] <= tag_r;
    end
    if (state_r == ST_RESP && out_free) begin
      out_data_r  <= lram_rdata;
      out_hit_r   <= hit_r;
      out_dirty_r <= old_dirty_r;
    end
  end

  dmwbc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_LINES * LINE_BYTES)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (lram_we),
    .wr_addr (lram_waddr),
    .wr_data (lram_wdata),
    .rd_addr (lram_raddr),
    .rd_data (lram_rdata)
  );

  dmwbc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_BYTES)
  ) u_backing_ram (
    .clk     (clk),
    .wr_en   (bmem_we),
    .wr_addr (bmem_waddr),
    .wr_data (bmem_wdata),
    .rd_addr (bmem_raddr),
    .rd_data (bmem_rdata)
  );

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_data_r;
  assign out_chan.hit       = out_hit_r;
  assign out_chan.was_dirty = out_dirty_r;

  // an invalid line is never dirty
  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (line_dirty_r & ~line_valid_r) == '0)
    else $error("dirty bit set on invalid line");

  // write-back only runs for a valid dirty line
  a_wb_line: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> (line_valid_r[idx_r] && line_dirty_r[idx_r]))
    else $error("write-back of clean or invalid line");

  // by the byte access the addressed line holds the requested tag
  a_access_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACCESS) |-> (line_valid_r[idx_r] && line_tag_r[idx_r] == tag_r))
    else $error("byte access to a line that was not installed");

  // transfer counter stays within one line
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB || state_r == ST_FILL) |-> (cnt_r <= CNT_W'(LINE_BYTES)))
    else $error("transfer counter out of range");

  // a pending result is never overwritten
  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && out_valid_r && !out_chan.ready) |=> (state_r == ST_RESP))
    else $error("result register overwritten");

endmodule

`default_nettype wire

### bench/direct_mapped_writeback_cache_tb.sv
// direct_mapped_writeback_cache_tb: self-checking bench for the write-back byte cache
// depends on dmwbc_pkg, dmwbc_if and the cache rtl; keeps its own mirror of lines and memory
`default_nettype none

module direct_mapped_writeback_cache_tb;
  import dmwbc_pkg::*;

  localparam int NUM_LINES  = NUM_LINES_DEF;
  localparam int LINE_BYTES = LINE_BYTES_DEF;
  localparam int MEM_BYTES  = MEM_BYTES_DEF;
  localparam int SPAN       = NUM_LINES * LINE_BYTES;
  localparam int TAG_W      = ADDR_W - $clog2(SPAN);
  localparam int RAND_WORDS = 1650;
  localparam int DRAIN_WAIT = 3 * (2 * LINE_BYTES + 6);
  // memory clear after reset, then worst case per word (dirty miss, full gap, full stall)
  localparam int CYCLE_LIMIT = 4 * (MEM_BYTES + (RAND_WORDS + 30) * (2 * LINE_BYTES + 6 + 20));

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              was_dirty;
  } read_result_t;

  // mirror of the cache: tag/valid/dirty per line, line bytes and backing memory
  class cache_mirror;
    bit                line_valid [NUM_LINES];
    int unsigned       line_tag   [NUM_LINES];
    bit                line_dirty [NUM_LINES];
    logic [DATA_W-1:0] line_data  [SPAN];
    logic [DATA_W-1:0] backing    [MEM_BYTES];
    read_result_t      expected_reads [$];
    int errors, reads, writes, hits, write_backs;

    function new();
      for (int i = 0; i < NUM_LINES; i++) begin
        line_valid[i] = 0;
        line_tag[i]   = 0;
        line_dirty[i] = 0;
      end
      for (int i = 0; i < SPAN; i++) line_data[i] = '0;
      for (int i = 0; i < MEM_BYTES; i++) backing[i] = '0;
      errors = 0; reads = 0; writes = 0; hits = 0; write_backs = 0;
    endfunction

    function int unsigned mem_index(int unsigned tg, int unsigned idx, int unsigned off);
      return ((tg * NUM_LINES + idx) * LINE_BYTES + off) % MEM_BYTES;
    endfunction

    function int pending();
      return expected_reads.size();
    endfunction

    function void note_access(logic [ADDR_W-1:0] address, logic action,
                              logic [DATA_W-1:0] wdata);
      int unsigned  off, idx, tg;
      bit           hit, old_dirty;
      read_result_t r;
      off = address % LINE_BYTES;
      idx = (address / LINE_BYTES) % NUM_LINES;
      tg  = address / SPAN;
      hit = line_valid[idx] && (line_tag[idx] == tg);
      old_dirty = line_dirty[idx];
      if (!hit) begin
        if (line_valid[idx] && line_dirty[idx]) begin
          write_backs++;
          for (int i = 0; i < LINE_BYTES; i++)
            backing[mem_index(line_tag[idx], idx, i)] = line_data[idx * LINE_BYTES + i];
        end
        line_tag[idx]   = tg;
        line_valid[idx] = 1;
        for (int i = 0; i < LINE_BYTES; i++)
          line_data[idx * LINE_BYTES + i] = backing[mem_index(tg, idx, i)];
      end
      if (action == ACT_WRITE) begin
        writes++;
        line_data[idx * LINE_BYTES + off] = wdata;
        line_dirty[idx] = 1;
      end else begin
        reads++;
        if (hit) hits++;
        else line_dirty[idx] = 0;
        r.read_data = line_data[idx * LINE_BYTES + off];
        r.hit       = hit;
        r.was_dirty = old_dirty;
        expected_reads.push_back(r);
      end
    endfunction

    function void check_read(logic [DATA_W-1:0] rd, logic hit, logic was_dirty);
      read_result_t e;
      if (expected_reads.size() == 0) begin
        $error("read result with none expected: read_data %0h hit %0b was_dirty %0b",
               rd, hit, was_dirty);
        errors++;
      end else begin
        e = expected_reads.pop_front();
        if (rd !== e.read_data) begin
          $error("read_data mismatch: expected %0h, got %0h", e.read_data, rd);
          errors++;
        end
        if (hit !== e.hit) begin
          $error("hit mismatch: expected %0b, got %0b", e.hit, hit);
          errors++;
        end
        if (was_dirty !== e.was_dirty) begin
          $error("was_dirty mismatch: expected %0b, got %0b", e.was_dirty, was_dirty);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  int   stall_left;
  int   cycle_count;

  cache_mirror mirror;

  // small pools of tags and lines so random traffic hits, conflicts and evicts
  logic [TAG_W-1:0] tag_pool  [4];
  int unsigned      line_pool [4];

  dmwbc_in_if  in_chan ();
  dmwbc_out_if out_chan ();

  direct_mapped_writeback_cache i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: ready drops in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // every read word that leaves the cache is checked against the mirror
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      mirror.check_read(out_chan.read_data, out_chan.hit, out_chan.was_dirty);
  end

  // hard stop in case the handshake hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  // one access word: hold valid until taken, then maybe leave a gap
  task automatic send_access(logic [ADDR_W-1:0] address, logic action,
                             logic [DATA_W-1:0] wdata);
    int gap;
    in_chan.valid      <= 1'b1;
    in_chan.address    <= address;
    in_chan.action     <= action;
    in_chan.write_data <= wdata;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    mirror.note_access(address, action, wdata);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every expected read result is back
  task automatic wait_for_reads();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  task automatic refresh_pools();
    for (int i = 0; i < 4; i++) begin
      tag_pool[i]  = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
      line_pool[i] = $urandom_range(0, NUM_LINES - 1);
    end
  endtask

  // mostly pooled tags, lines from the pool or random; a tenth fully random addresses
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned tg, idx, off;
    if ($urandom_range(0, 9) == 0) return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
    tg  = 32'(tag_pool[$urandom_range(0, 3)]);
    idx = ($urandom_range(0, 1) == 0) ? line_pool[$urandom_range(0, 3)]
                                      : $urandom_range(0, NUM_LINES - 1);
    off = $urandom_range(0, LINE_BYTES - 1);
    return ADDR_W'((tg * NUM_LINES + idx) * LINE_BYTES + off);
  endfunction

  initial begin
    mirror = new();
    rst_n = 1'b0;
    idle_on = 1'b0;
    stall_left = 0;
    in_chan.valid = 1'b0;
    in_chan.address = '0;
    in_chan.action = ACT_READ;
    in_chan.write_data = '0;
    out_chan.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: cold miss, hits, dirty evictions and address extremes
    send_access(16'h0000, ACT_READ,  8'h00);  // invalid line, clean miss
    send_access(16'h0000, ACT_WRITE, 8'hA5);  // write hit
    send_access(16'h0000, ACT_READ,  8'h00);  // read hit on a dirty line
    send_access(16'hFFFF, ACT_WRITE, 8'hFF);  // write miss, top address
    send_access(16'hFFFF, ACT_READ,  8'h00);
    send_access(16'h00FF, ACT_READ,  8'h00);  // dirty miss, write-back of the top line
    send_access(16'hFFFF, ACT_READ,  8'h00);  // refetch from memory
    send_access(16'h0107, ACT_WRITE, 8'h5A);  // write miss over a dirty line
    send_access(16'h0000, ACT_READ,  8'h00);  // dirty read miss
    send_access(16'h0107, ACT_READ,  8'h00);
    send_access(16'h8040, ACT_WRITE, 8'h00);
    send_access(16'h8040, ACT_READ,  8'h00);
    send_access(16'h7FBF, ACT_WRITE, 8'h80);
    send_access(16'h7FB8, ACT_READ,  8'h00);  // other byte of the same line
    send_access(16'h7FBF, ACT_READ,  8'h00);
    send_access(16'h5555, ACT_WRITE, 8'h55);
    send_access(16'hAAAA, ACT_WRITE, 8'hAA);
    send_access(16'h5555, ACT_READ,  8'h00);
    send_access(16'hAAAA, ACT_READ,  8'h00);
    send_access(16'h55AD, ACT_READ,  8'h00);  // conflicts with 0xAAAA, dirty miss
    wait_for_reads();

    // random traffic, idling on both sides except in the last stretch
    idle_on = 1'b1;
    refresh_pools();
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 200 == 199) refresh_pools();
      if (n == RAND_WORDS / 2) wait_for_reads();
      if (n == RAND_WORDS - 250) idle_on = 1'b0;
      send_access(pick_address(), logic'($urandom_range(0, 1)),
                  DATA_W'($urandom_range(0, 255)));
    end

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
    // a trailing write may still be busy in the backing memory
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d reads (%0d hits) and %0d writes, %0d dirty write-backs",
             mirror.reads, mirror.hits, mirror.writes, mirror.write_backs);
    $display("errors: %0d", mirror.errors);
    if (mirror.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

### direct_mapped_writeback_cache.f
design/dmwbc_pkg.sv
design/dmwbc_if.sv
design/dmwbc_ram.sv
design/direct_mapped_writeback_cache.sv
bench/direct_mapped_writeback_cache_tb.sv
